### rtl/core/range_timeout_encoder_core_macros.svh
// Assertion helpers for the range timeout encoder.
`ifndef RANGE_TIMEOUT_ENCODER_CORE_MACROS_SVH
`define RANGE_TIMEOUT_ENCODER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define RTE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("range timeout encoder: same-cycle check failed");

// Check cons in the cycle after ante.
`define RTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("range timeout encoder: next-cycle check failed");

`endif

### rtl/core/rte_pkg.sv
package rte_pkg;

  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [31:0] OSC_NUMERATOR    = 32'h4000_0000;
  localparam logic [11:0] MACRO_MULT       = 12'd2304;
  localparam logic [31:0] CONT_OVERHEAD_US = 32'd2500;
  localparam logic [31:0] AUTO_OVERHEAD_US = 32'd4300;
  localparam logic [10:0] PLL_SCALE        = 11'd1055;
  localparam logic [31:0] PLL_ROUND        = 32'd500;
  localparam logic [31:0] PLL_DIV          = 32'd1000;
  localparam logic [9:0]  US_PER_MS        = 10'd1000;
  localparam logic [7:0]  BUDGET_RESET     = 8'd50;
  localparam logic [11:0] PERIOD_RESET     = 12'd0;

  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_OSC,
    ST_MACRO,
    ST_PREP,
    ST_LAUNCH,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_TICK,
    ST_DIV_A,
    ST_NORM_A,
    ST_DIV_B,
    ST_NORM_B,
    ST_FAIL
  } rte_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]  budget_ms;
    logic [11:0] period_ms;
  } cfg_t;

endpackage

### rtl/core/rte_div.sv
module rte_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rte_pkg::div_req_t req,
  output rte_pkg::div_rsp_t rsp
);
  import rte_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W:0]       rem_shift;
  logic                 fits;

  assign rem_shift = {rem_r, quo_r[DIV_W-1]};
  assign fits      = rem_shift >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DIV_W'(rem_shift - {1'b0, dsr_r});
      end else begin
        rem_nxt = rem_shift[DIV_W-1:0];
      end
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### rtl/core/rte_cfg.sv
module rte_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rte_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rte_pkg::cfg_t                  cfg
);
  import rte_pkg::*;

  logic [7:0]  budget_r, budget_nxt;
  logic [11:0] period_r, period_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    budget_nxt = budget_r;
    period_nxt = period_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_BUDGET: budget_nxt = pwdata[7:0];
        REG_PERIOD: period_nxt = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BUDGET: prdata = {24'd0, budget_r};
      REG_PERIOD: prdata = {20'd0, period_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
      period_r <= PERIOD_RESET;
    end else begin
      budget_r <= budget_nxt;
      period_r <= period_nxt;
    end
  end

  assign cfg.budget_ms = budget_r;
  assign cfg.period_ms = period_r;

endmodule

### rtl/core/range_timeout_encoder_core.sv
// Range timeout encoder. Pulse start while busy is low to hand over one request
// (oscillator word and PLL calibration word); busy stays high until the result
// is out. The result appears for exactly one cycle with out_strobe high and
// cannot be held off, so capture it on that cycle. One 32-step shared restoring
// divider runs three times in continuous mode and four in autonomous mode, and
// each of the two timeouts then takes up to 24 normalization shifts. A zero
// oscillator word returns with out_ok low. Write budget_ms and period_ms over
// the APB port only while busy is low and no result is pending.
module range_timeout_encoder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    in_osc_value,
  input  logic [15:0]                    in_pll_calibration,
  output logic                           out_strobe,
  output logic                           out_ok,
  output logic [31:0]                    out_period_ticks,
  output logic [15:0]                    out_timeout_a,
  output logic [15:0]                    out_timeout_b,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rte_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rte_pkg::*;

  `include "range_timeout_encoder_core_macros.svh"

  cfg_t       cfg;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  rte_state_t state_r, state_nxt;
  logic [9:0]  pll_r, pll_nxt;
  logic [25:0] macro_r, macro_nxt;
  logic [31:0] num_r, num_nxt;
  logic [23:0] div_a_r, div_a_nxt;
  logic [23:0] div_b_r, div_b_nxt;
  logic [21:0] prod_r, prod_nxt;
  logic [31:0] ticks_r, ticks_nxt;
  logic [31:0] mant_r, mant_nxt;
  logic [4:0]  expo_r, expo_nxt;
  logic [15:0] ta_r, ta_nxt;

  logic        strobe_r, strobe_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] oticks_r, oticks_nxt;
  logic [15:0] ota_r, ota_nxt;
  logic [15:0] otb_r, otb_nxt;

  logic [31:0] macro_prod;
  logic [29:0] mult_b;
  logic [23:0] div_a_c;
  logic [23:0] div_b_c;
  logic [17:0] bud_us;
  logic [31:0] bud_cont;
  logic [31:0] bud_auto;
  logic [32:0] tick_prod;
  logic [31:0] tick_num;
  logic [31:0] num_a;
  logic [31:0] num_b;

  rte_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign macro_prod = 32'(div_rsp.quotient * 32'(MACRO_MULT));
  assign div_a_c    = macro_r[25:2];
  assign mult_b     = {1'b0, macro_r, 3'b000} + {2'b00, macro_r, 2'b00};
  assign div_b_c    = mult_b[29:6];
  assign bud_us     = 18'(cfg.budget_ms) * 18'(US_PER_MS);
  assign bud_cont   = 32'(bud_us) - CONT_OVERHEAD_US;
  assign bud_auto   = (32'(bud_us) - AUTO_OVERHEAD_US) >> 1;
  assign tick_prod  = 33'(prod_r) * 33'(PLL_SCALE);
  assign tick_num   = tick_prod[31:0] + PLL_ROUND;
  assign num_a      = num_r + 32'(div_a_r[23:1]);
  assign num_b      = num_r + 32'(div_b_r[23:1]);

  always_comb begin
    state_nxt  = state_r;
    pll_nxt    = pll_r;
    macro_nxt  = macro_r;
    num_nxt    = num_r;
    div_a_nxt  = div_a_r;
    div_b_nxt  = div_b_r;
    prod_nxt   = prod_r;
    ticks_nxt  = ticks_r;
    mant_nxt   = mant_r;
    expo_nxt   = expo_r;
    ta_nxt     = ta_r;
    strobe_nxt = 1'b0;
    ok_nxt     = ok_r;
    oticks_nxt = oticks_r;
    ota_nxt    = ota_r;
    otb_nxt    = otb_r;
    div_req    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          pll_nxt = in_pll_calibration[9:0];
          if (in_osc_value == 16'd0) begin
            state_nxt = ST_FAIL;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = OSC_NUMERATOR;
            div_req.divisor  = {16'd0, in_osc_value};
            state_nxt        = ST_DIV_OSC;
          end
        end
      end
      ST_DIV_OSC: begin
        if (div_rsp.done) begin
          macro_nxt = macro_prod[31:6];
          state_nxt = ST_MACRO;
        end
      end
      ST_MACRO: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (div_a_c == 24'd0 || div_b_c == 24'd0) begin
          state_nxt = ST_FAIL;
        end else begin
          div_a_nxt = div_a_c;
          div_b_nxt = div_b_c;
          if (cfg.period_ms == 12'd0) begin
            num_nxt = {bud_cont[19:0], 12'd0};
          end else begin
            num_nxt = {bud_auto[19:0], 12'd0};
          end
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (cfg.period_ms == 12'd0) begin
          ticks_nxt        = '0;
          div_req.start    = 1'b1;
          div_req.dividend = num_a;
          div_req.divisor  = 32'(div_a_r);
          state_nxt        = ST_DIV_A;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt  = 22'(cfg.period_ms) * 22'(pll_r);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        div_req.start    = 1'b1;
        div_req.dividend = tick_num;
        div_req.divisor  = PLL_DIV;
        state_nxt        = ST_DIV_TICK;
      end
      ST_DIV_TICK: begin
        if (div_rsp.done) begin
          ticks_nxt        = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = num_a;
          div_req.divisor  = 32'(div_a_r);
          state_nxt        = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (div_rsp.done) begin
          mant_nxt  = div_rsp.quotient - 32'd1;
          expo_nxt  = '0;
          state_nxt = ST_NORM_A;
        end
      end
      ST_NORM_A: begin
        if (|mant_r[31:8]) begin
          mant_nxt = mant_r >> 1;
          expo_nxt = expo_r + 5'd1;
        end else begin
          ta_nxt           = {3'd0, expo_r, mant_r[7:0]};
          div_req.start    = 1'b1;
          div_req.dividend = num_b;
          div_req.divisor  = 32'(div_b_r);
          state_nxt        = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_rsp.done) begin
          mant_nxt  = div_rsp.quotient - 32'd1;
          expo_nxt  = '0;
          state_nxt = ST_NORM_B;
        end
      end
      ST_NORM_B: begin
        if (|mant_r[31:8]) begin
          mant_nxt = mant_r >> 1;
          expo_nxt = expo_r + 5'd1;
        end else begin
          strobe_nxt = 1'b1;
          ok_nxt     = 1'b1;
          oticks_nxt = ticks_r;
          ota_nxt    = ta_r;
          otb_nxt    = {3'd0, expo_r, mant_r[7:0]};
          state_nxt  = ST_IDLE;
        end
      end
      ST_FAIL: begin
        strobe_nxt = 1'b1;
        ok_nxt     = 1'b0;
        oticks_nxt = '0;
        ota_nxt    = '0;
        otb_nxt    = '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pll_r    <= pll_nxt;
    macro_r  <= macro_nxt;
    num_r    <= num_nxt;
    div_a_r  <= div_a_nxt;
    div_b_r  <= div_b_nxt;
    prod_r   <= prod_nxt;
    ticks_r  <= ticks_nxt;
    mant_r   <= mant_nxt;
    expo_r   <= expo_nxt;
    ta_r     <= ta_nxt;
    ok_r     <= ok_nxt;
    oticks_r <= oticks_nxt;
    ota_r    <= ota_nxt;
    otb_r    <= otb_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_ok           = ok_r;
  assign out_period_ticks = oticks_r;
  assign out_timeout_a    = ota_r;
  assign out_timeout_b    = otb_r;

  `RTE_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `RTE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `RTE_ASSERT_SAME(a_fail_zero, clk, rst_n, out_strobe && !out_ok,
    out_period_ticks == 32'd0 && out_timeout_a == 16'd0 && out_timeout_b == 16'd0)
  `RTE_ASSERT_SAME(a_expo_range, clk, rst_n, out_strobe && out_ok,
    out_timeout_a[15:8] <= 8'd24 && out_timeout_b[15:8] <= 8'd24)
  `RTE_ASSERT_SAME(a_div_done_waiting, clk, rst_n, div_rsp.done,
    state_r == ST_DIV_OSC || state_r == ST_DIV_TICK || state_r == ST_DIV_A ||
    state_r == ST_DIV_B)

endmodule

### verif/rte_timing_checker.sv
`timescale 1ns / 1ps

module rte_timing_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [15:0]                    osc_value,
  input  logic [15:0]                    pll_calibration,
  input  logic                           strobe,
  input  logic                           ok,
  input  logic [31:0]                    period_ticks,
  input  logic [15:0]                    timeout_a,
  input  logic [15:0]                    timeout_b,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rte_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             failures,
  output int                             outstanding
);
  import rte_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BUDGET = {REG_BUDGET, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};
  localparam logic [31:0] PHASE_A_MULT  = 32'd16;
  localparam logic [31:0] PHASE_B_MULT  = 32'd12;
  localparam logic [31:0] MANT_OVERFLOW = 32'hFFFF_FF00;

  typedef struct packed {
    logic        ok;
    logic [31:0] ticks;
    logic [15:0] timeout_a;
    logic [15:0] timeout_b;
  } timing_t;

  timing_t     pending_timings[$];
  logic [7:0]  budget_ms;
  logic [11:0] period_ms;

  function automatic logic [15:0] encode_exp_mant(input logic [31:0] scaled,
                                                  input logic [31:0] divisor);
    logic [31:0] mant;
    logic [7:0]  expo;
    mant = (scaled + (divisor >> 1)) / divisor - 32'd1;
    expo = '0;
    while ((mant & MANT_OVERFLOW) != '0) begin
      mant = mant >> 1;
      expo = expo + 8'd1;
    end
    return {expo, mant[7:0]};
  endfunction

  function automatic timing_t predict_timing(input logic [15:0] osc,
                                             input logic [15:0] pll_word,
                                             input logic [7:0]  budget,
                                             input logic [11:0] period);
    logic [31:0] budget_us;
    logic [31:0] macro;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic [31:0] ticks;
    timing_t     res;
    res = '0;
    if (osc == '0) return res;
    budget_us = 32'(budget) * 32'(US_PER_MS);
    macro = (32'(MACRO_MULT) * (OSC_NUMERATOR / 32'(osc))) >> 6;
    ticks = '0;
    if (period == '0) begin
      budget_us = budget_us - CONT_OVERHEAD_US;
    end else begin
      ticks = (32'(period) * 32'(pll_word[9:0]) * 32'(PLL_SCALE) + PLL_ROUND) / PLL_DIV;
      budget_us = (budget_us - AUTO_OVERHEAD_US) >> 1;
    end
    budget_us = budget_us << 12;
    div_a = (macro * PHASE_A_MULT) >> 6;
    div_b = (macro * PHASE_B_MULT) >> 6;
    if (div_a == '0 || div_b == '0) return res;
    res.ok        = 1'b1;
    res.ticks     = ticks;
    res.timeout_a = encode_exp_mant(budget_us, div_a);
    res.timeout_b = encode_exp_mant(budget_us, div_b);
    return res;
  endfunction

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    timing_t want;
    timing_t got;
    if (!rst_n) begin
      budget_ms = BUDGET_RESET;
      period_ms = PERIOD_RESET;
      pending_timings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_BUDGET) begin
          budget_ms = pwdata[7:0];
        end else if (paddr == ADDR_PERIOD) begin
          period_ms = pwdata[11:0];
        end
      end
      if (strobe) begin
        got = {ok, period_ticks, timeout_a, timeout_b};
        if (pending_timings.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: ok=%0b ticks=%08h a=%04h b=%04h",
                     got.ok, got.ticks, got.timeout_a, got.timeout_b);
        end else begin
          want = pending_timings.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display("mismatch ok/ticks/a/b exp %0b/%08h/%04h/%04h got %0b/%08h/%04h/%04h",
                       want.ok, want.ticks, want.timeout_a, want.timeout_b,
                       got.ok, got.ticks, got.timeout_a, got.timeout_b);
          end
        end
      end
      if (start && !busy)
        pending_timings.push_back(predict_timing(osc_value, pll_calibration,
                                                 budget_ms, period_ms));
    end
    outstanding = pending_timings.size();
  end

endmodule

### verif/range_timeout_encoder_core_tb.sv
`timescale 1ns / 1ps

module range_timeout_encoder_core_tb;
  import rte_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BUDGET = {REG_BUDGET, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [15:0]           in_osc_value;
  logic [15:0]           in_pll_calibration;
  logic                  out_strobe;
  logic                  out_ok;
  logic [31:0]           out_period_ticks;
  logic [15:0]           out_timeout_a;
  logic [15:0]           out_timeout_b;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int cycle_count = 0;
  int request_count = 0;
  int write_count = 0;
  int check_failures;
  int pending_results;
  bit idle_on;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  range_timeout_encoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_osc_value      (in_osc_value),
    .in_pll_calibration(in_pll_calibration),
    .out_strobe        (out_strobe),
    .out_ok            (out_ok),
    .out_period_ticks  (out_period_ticks),
    .out_timeout_a     (out_timeout_a),
    .out_timeout_b     (out_timeout_b),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  rte_timing_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .osc_value      (in_osc_value),
    .pll_calibration(in_pll_calibration),
    .strobe         (out_strobe),
    .ok             (out_ok),
    .period_ticks   (out_period_ticks),
    .timeout_a      (out_timeout_a),
    .timeout_b      (out_timeout_b),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .failures       (check_failures),
    .outstanding    (pending_results)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue(input logic [15:0] osc, input logic [15:0] pll);
    int gap;
    start              <= 1'b1;
    in_osc_value       <= osc;
    in_pll_calibration <= pll;
    @(posedge clk);
    while (busy) @(posedge clk);
    request_count++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1)
        while (busy) @(negedge clk);
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results != 0 || busy) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    write_count++;
  endtask

  task automatic reconfigure(input logic [7:0] budget, input logic [11:0] period);
    drain();
    reg_write(ADDR_BUDGET, {24'($urandom()), budget});
    reg_write(ADDR_PERIOD, {20'($urandom()), period});
  endtask

  initial begin
    int          phase;
    int          n;
    logic [7:0]  budget;
    logic [11:0] period;
    logic [15:0] osc;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_osc_value       = '0;
    in_pll_calibration = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    idle_on            = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    issue(16'h0000, 16'h0000);
    issue(16'h0000, 16'hFFFF);
    issue(16'hFFFF, 16'hFFFF);
    issue(16'hFFFF, 16'h0000);
    issue(16'h0001, 16'h03FF);
    issue(16'h0002, 16'h1234);
    issue(16'd576, 16'hFC00);
    issue(16'd577, 16'h0200);
    issue(16'd600, 16'h5555);
    issue(16'd8000, 16'hAAAA);
    reconfigure(8'd200, 12'd3000);
    issue(16'hFFFF, 16'h03FF);
    issue(16'd1000, 16'h0000);
    issue(16'd600, 16'hFFFF);
    reconfigure(8'd10, 12'd1);
    issue(16'hFFFF, 16'h03FF);
    issue(16'd1234, 16'h0200);
    reconfigure(8'd5, 12'd100);
    issue(16'd600, 16'h0155);
    issue(16'd3000, 16'h02AA);
    reconfigure(8'd3, 12'd0);
    issue(16'd600, 16'h0001);
    reconfigure(8'd255, 12'd4095);
    issue(16'hFFFF, 16'hFFFF);
    issue(16'd700, 16'h03FF);
    reconfigure(8'd0, 12'd0);
    issue(16'd40000, 16'h8000);

    for (phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 9))
        0:       budget = 8'd10;
        1:       budget = 8'd200;
        2:       budget = 8'($urandom_range(0, 255));
        3:       budget = 8'($urandom_range(3, 5));
        default: budget = 8'($urandom_range(10, 200));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: period = 12'd0;
        3:       period = 12'd3000;
        4:       period = 12'd4095;
        5:       period = 12'($urandom_range(0, 4095));
        default: period = 12'($urandom_range(1, 3000));
      endcase
      reconfigure(budget, period);
      idle_on = (phase < 8) && (phase % 3 != 1);
      for (n = 0; n < 50; n++) begin
        if (idle_on && $urandom_range(0, 24) == 0) drain();
        case ($urandom_range(0, 15))
          0:       osc = 16'h0000;
          1, 2:    osc = 16'($urandom_range(1, 3400));
          default: osc = 16'($urandom());
        endcase
        issue(osc, 16'($urandom()));
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d requests and %0d register writes over both timing modes,",
             request_count, write_count);
    $display("including zero oscillator words, wrapped divisors and zero quotients");
    if (check_failures == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
